>>> rtl/tccw_pkg.sv
package tccw_pkg;

    // Item kinds carried on s_kind.
    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_RAW   = 3'd1;
    localparam logic [2:0] KIND_SET   = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Character codes with a meaning of their own.
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;

    // Attribute byte after reset: light gray on black.
    localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

    // Fixed-point scale of the reciprocals used to reduce cursor requests.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

    // Widths of the payload fields.
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 11;

endpackage

>>> rtl/tccw_cell_mem.sv
module tccw_cell_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/text_console_cell_writer.sv
// Text console cell writer.
// Input channel (s_valid/s_ready): one beat per item; s_kind selects a
// character write, a raw cell write, a cursor set, a clear screen or a cell
// read. The user writes the attribute byte for characters and blanks via
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not check.
// Result channel (m_valid/m_ready): exactly one beat per item, in order,
// carrying read data (zero except for reads) and the cursor position after
// the item.
// Timing: character, raw and unknown items produce their result at the edge
// that accepts them, so they run at one item per cycle while results are
// taken. A read waits on the registered RAM read; a cursor set passes two
// multiply stages (ST_SET_Q, ST_SET_R) for the modulo reduction. Newline and
// clear screen blank their cells (rest of the row, or all WIDTH*HEIGHT) one
// by one through the single write port of the cell RAM.
// A finished result waits in the output register; the next item is taken
// once the block is idle and that register is empty or being drained, so a
// stalled receiver holds off the input once one result is waiting.
// Reset clears the cursor to row 0, column 0 and the color to 7. The cell
// RAM is not cleared; cells are meant to be read only after a write or clear.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_kind,
    input  logic [CHAR_W-1:0]   s_character,
    input  logic [CELL_W-1:0]   s_raw_cell,
    input  logic [7:0]          s_column,
    input  logic [7:0]          s_row,
    input  logic [POS_W-1:0]    s_cell_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CELL_W-1:0]   m_read_data,
    output logic [POS_W-1:0]    m_cursor_position
);

    localparam int CELL_COUNT = WIDTH * HEIGHT;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W      = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int ROW_W      = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int PROD_W     = RECIP_SHIFT + 9;

    localparam logic [PROD_W-1:0] RECIP_COL = PROD_W'((RECIP_ONE + WIDTH - 1) / WIDTH);
    localparam logic [PROD_W-1:0] RECIP_ROW = PROD_W'((RECIP_ONE + HEIGHT - 1) / HEIGHT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SET_Q,
        ST_SET_R
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]        text_color_reg;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_last_reg, fill_last_next;
    logic [7:0]        set_col_reg, set_col_next;
    logic [7:0]        set_row_reg, set_row_next;
    logic [7:0]        q_col_reg, q_col_next;
    logic [7:0]        q_row_reg, q_row_next;
    logic              rd_hit_reg, rd_hit_next;

    logic              m_valid_reg;
    logic [CELL_W-1:0] m_read_data_reg;
    logic [POS_W-1:0]  m_cursor_position_reg;

    logic              accept;
    logic              res_load;
    logic [CELL_W-1:0] res_data;
    logic [ADDR_W-1:0] res_pos;

    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] cur_idx;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  row_inc;
    logic              col_wrap;
    logic              addr_in_range;

    logic [PROD_W-1:0] prod_col;
    logic [PROD_W-1:0] prod_row;
    logic [15:0]       rem_col;
    logic [15:0]       rem_row;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [15:0]       mem_rdata;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Linear index of the cursor and the cursor one step on.
    assign row_base = ADDR_W'(cursor_row_reg) * ADDR_W'(WIDTH);
    assign cur_idx  = row_base + ADDR_W'(cursor_col_reg);
    assign col_wrap = (cursor_col_reg == COL_W'(WIDTH - 1));
    assign adv_col  = col_wrap ? '0 : cursor_col_reg + COL_W'(1);
    assign row_inc  = (cursor_row_reg == ROW_W'(HEIGHT - 1)) ? '0
                                                             : cursor_row_reg + ROW_W'(1);

    assign addr_in_range = (32'(s_cell_address) < CELL_COUNT);

    // Modulo reduction of a cursor request: quotient by reciprocal, then remainder.
    assign prod_col = PROD_W'(set_col_reg) * RECIP_COL;
    assign prod_row = PROD_W'(set_row_reg) * RECIP_ROW;
    assign rem_col  = 16'(set_col_reg) - 16'(q_col_reg) * 16'(WIDTH);
    assign rem_row  = 16'(set_row_reg) - 16'(q_row_reg) * 16'(HEIGHT);

    // Sequencer: decodes each item and drives the cell RAM write port and read enable.
    always_comb begin
        state_next      = state_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        fill_addr_next  = fill_addr_reg;
        fill_last_next  = fill_last_reg;
        set_col_next    = set_col_reg;
        set_row_next    = set_row_reg;
        q_col_next      = q_col_reg;
        q_row_next      = q_row_reg;
        rd_hit_next     = rd_hit_reg;
        res_load        = 1'b0;
        res_data        = '0;
        mem_we          = 1'b0;
        mem_waddr       = cur_idx;
        mem_wdata       = {text_color_reg, s_character};
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_CHAR: begin
                            if (s_character == NEWLINE_CODE) begin
                                // Blank the rest of the row, then go to the next row.
                                fill_addr_next  = cur_idx;
                                fill_last_next  = row_base + ADDR_W'(WIDTH - 1);
                                cursor_col_next = '0;
                                cursor_row_next = row_inc;
                                state_next      = ST_FILL;
                            end else begin
                                mem_we          = 1'b1;
                                cursor_col_next = adv_col;
                                cursor_row_next = col_wrap ? row_inc : cursor_row_reg;
                                res_load        = 1'b1;
                            end
                        end
                        KIND_RAW: begin
                            mem_we          = 1'b1;
                            mem_wdata       = s_raw_cell;
                            cursor_col_next = adv_col;
                            cursor_row_next = col_wrap ? row_inc : cursor_row_reg;
                            res_load        = 1'b1;
                        end
                        KIND_SET: begin
                            set_col_next = s_column;
                            set_row_next = s_row;
                            state_next   = ST_SET_Q;
                        end
                        KIND_CLEAR: begin
                            fill_addr_next  = '0;
                            fill_last_next  = ADDR_W'(CELL_COUNT - 1);
                            cursor_col_next = '0;
                            cursor_row_next = '0;
                            state_next      = ST_FILL;
                        end
                        KIND_READ: begin
                            mem_re      = addr_in_range;
                            rd_hit_next = addr_in_range;
                            state_next  = ST_READ;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_data   = rd_hit_reg ? mem_rdata : '0;
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = {text_color_reg, BLANK_CODE};
                if (fill_addr_reg == fill_last_reg) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    fill_addr_next = fill_addr_reg + ADDR_W'(1);
                end
            end
            ST_SET_Q: begin
                q_col_next = prod_col[RECIP_SHIFT +: 8];
                q_row_next = prod_row[RECIP_SHIFT +: 8];
                state_next = ST_SET_R;
            end
            ST_SET_R: begin
                cursor_col_next = COL_W'(rem_col);
                cursor_row_next = ROW_W'(rem_row);
                res_load        = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Position reported with a result is that of the updated cursor.
    assign res_pos = ADDR_W'(cursor_row_next) * ADDR_W'(WIDTH) + ADDR_W'(cursor_col_next);

    // State, cursor, color and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            text_color_reg <= TEXT_COLOR_RESET;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            if (cfg_wr_en) begin
                text_color_reg <= cfg_wr_data;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        fill_addr_reg <= fill_addr_next;
        fill_last_reg <= fill_last_next;
        set_col_reg   <= set_col_next;
        set_row_reg   <= set_row_next;
        q_col_reg     <= q_col_next;
        q_row_reg     <= q_row_next;
        rd_hit_reg    <= rd_hit_next;
        if (res_load) begin
            m_read_data_reg       <= res_data;
            m_cursor_position_reg <= POS_W'(res_pos);
        end
    end

    tccw_cell_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (ADDR_W'(s_cell_address)),
        .rd_data (mem_rdata)
    );

    assign m_valid           = m_valid_reg;
    assign m_read_data       = m_read_data_reg;
    assign m_cursor_position = m_cursor_position_reg;

endmodule

>>> rtl/tccw_checker.sv
module tccw_checker #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_read_data,
    input logic [10:0] m_cursor_position
);

    localparam int CELL_COUNT = WIDTH * HEIGHT;

    // Nothing is offered on the result side right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
                                && $stable(m_cursor_position))
        else $error("stalled result beat changed");

    // While a result waits on a stalled receiver, no new item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while a result is stalled");

    // The reported cursor lies inside the screen whenever the screen has at most 2048 cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CELL_COUNT > 2048) || (32'(m_cursor_position) < CELL_COUNT))
        else $error("cursor position outside the screen");

endmodule

bind text_console_cell_writer tccw_checker #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
) u_tccw_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_read_data       (m_read_data),
    .m_cursor_position (m_cursor_position)
);
